/* design/octet_counter_rate_meter_defines.svh */
// ----------------------------------------------------------------------------
// Octet counter rate meter assertion macros
// Shared concurrent assertion helpers for the rate meter.
// ----------------------------------------------------------------------------
`ifndef OCTET_COUNTER_RATE_METER_DEFINES_SVH
`define OCTET_COUNTER_RATE_METER_DEFINES_SVH

// Assertion sampled on the rising clock edge and held off during reset.
`define OCRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the assertion above.
`define OCRM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/ocrm_pkg.sv */
// ----------------------------------------------------------------------------
// Octet counter rate meter package
// Types and constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package ocrm_pkg;

  localparam int unsigned RATE_W   = 38;
  localparam int unsigned AVG_W    = 46;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned OCT_W    = 64;
  localparam int unsigned DIVD_W   = 77;
  localparam int unsigned TAP_W    = 4;
  localparam int unsigned NUM_AVG  = 6;

  localparam logic [RATE_W-1:0] LIMIT_RESET = 38'd200000000000;

  // Register byte addresses.
  localparam logic [3:0] ADDR_LIMIT = 4'd0;
  localparam logic [3:0] ADDR_TAP   = 4'd8;

  typedef enum logic [1:0] {
    ST_FIRST = 2'd0,
    ST_BACK  = 2'd1,
    ST_SEED  = 2'd2,
    ST_AVG   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_IN,
    B_DIV_OUT,
    B_AVG_MUL,
    B_AVG_ADD,
    B_EMIT
  } back_state_e;

  // One classified sample as handed from front to back.
  typedef struct packed {
    status_e             kind;
    logic [OCT_W-1:0]    d_in;
    logic [OCT_W-1:0]    d_out;
    logic [TIME_W-1:0]   dt;
  } entry_t;

  typedef struct packed {
    logic [RATE_W-1:0] in_rate;
    logic [RATE_W-1:0] out_rate;
    logic [RATE_W-1:0] in_avg_fast;
    logic [RATE_W-1:0] in_avg_mid;
    logic [RATE_W-1:0] in_avg_slow;
    logic [RATE_W-1:0] out_avg_fast;
    logic [RATE_W-1:0] out_avg_mid;
    logic [RATE_W-1:0] out_avg_slow;
    logic [RATE_W-1:0] in_hist;
    logic [RATE_W-1:0] out_hist;
    status_e           status;
  } result_t;

  // Q16 weight of the new rate for average slot idx (fast, mid, slow, repeated).
  function automatic logic [15:0] avg_weight(input logic [2:0] idx);
    logic [15:0] w;
    case (idx)
      3'd0, 3'd3: w = 16'd32768;
      3'd1, 3'd4: w = 16'd6554;
      3'd2, 3'd5: w = 16'd1311;
      default:    w = 16'd32768;
    endcase
    return w;
  endfunction

endpackage

/* design/ocrm_front.sv */
// ----------------------------------------------------------------------------
// Rate meter front end
// Accepts samples, keeps the previous one and classifies each new sample.
// ----------------------------------------------------------------------------
module ocrm_front import ocrm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TIME_W-1:0] time_ms_i,
  input  logic [OCT_W-1:0]  in_octets_i,
  input  logic [OCT_W-1:0]  out_octets_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output entry_t            q_entry_o
);

  logic [OCT_W-1:0]  prev_in_q, prev_in_d;
  logic [OCT_W-1:0]  prev_out_q, prev_out_d;
  logic [TIME_W-1:0] prev_time_q, prev_time_d;
  logic              older_zero_q, older_zero_d;
  logic              first, went_back, forward;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify against the previous sample.
  always_comb begin
    first     = (prev_in_q == '0);
    went_back = (in_octets_i < prev_in_q) || (out_octets_i < prev_out_q);
    forward   = (time_ms_i >= prev_time_q);
    q_entry_o.d_in  = in_octets_i - prev_in_q;
    q_entry_o.d_out = out_octets_i - prev_out_q;
    q_entry_o.dt    = forward ? (time_ms_i - prev_time_q) : '0;
    if (first) begin
      q_entry_o.kind = ST_FIRST;
    end else if (went_back) begin
      q_entry_o.kind = ST_BACK;
    end else if (older_zero_q) begin
      q_entry_o.kind = ST_SEED;
    end else begin
      q_entry_o.kind = ST_AVG;
    end
    prev_in_d    = q_push_o ? in_octets_i : prev_in_q;
    prev_out_d   = q_push_o ? out_octets_i : prev_out_q;
    prev_time_d  = q_push_o ? time_ms_i : prev_time_q;
    older_zero_d = q_push_o ? first : older_zero_q;
  end

  // Previous sample registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in_q    <= '0;
      prev_out_q   <= '0;
      prev_time_q  <= '0;
      older_zero_q <= 1'b1;
    end else begin
      prev_in_q    <= prev_in_d;
      prev_out_q   <= prev_out_d;
      prev_time_q  <= prev_time_d;
      older_zero_q <= older_zero_d;
    end
  end

endmodule

/* design/ocrm_queue.sv */
// ----------------------------------------------------------------------------
// Rate meter sample queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ocrm_queue import ocrm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t entry_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* design/ocrm_back.sv */
// ----------------------------------------------------------------------------
// Rate meter back end
// Serial rate division, limit check, history and weighted averages.
// ----------------------------------------------------------------------------
module ocrm_back import ocrm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  entry_t            q_entry_i,
  output logic              q_pop_o,
  input  logic [RATE_W-1:0] rate_limit_i,
  input  logic [TAP_W-1:0]  history_tap_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           result_o
);

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  back_state_e         state_q, state_d;
  entry_t              ent_q;
  logic [DIVD_W-1:0]   div_x_q, div_quo_q;
  logic [TIME_W-1:0]   div_r_q;
  logic [6:0]          div_cnt_q;
  logic [RATE_W-1:0]   cur_in_q, cur_out_q;
  logic [AVG_W-1:0]    avg_q [NUM_AVG];
  logic [RATE_W-1:0]   hist_in_q [HISTORY_DEPTH];
  logic [RATE_W-1:0]   hist_out_q [HISTORY_DEPTH];
  logic [2:0]          idx_q;
  logic [61:0]         p_new_q, p_old_q;
  logic                out_valid_q;
  result_t             result_q;

  logic                out_free, div_busy, rate_ok;
  logic [TIME_W:0]     rr, rsub;
  logic                ge;
  logic [63:0]         blend_sum;
  logic [RATE_W-1:0]   avg_rate;
  logic [15:0]         w;
  logic [8:0]          tap_ext;
  logic [IDX_W-1:0]    tap;

  // Times 8000 as shifts: 8192 - 128 - 64.
  function automatic logic [DIVD_W-1:0] times8000(input logic [OCT_W-1:0] d);
    logic [DIVD_W-1:0] e;
    e = {13'b0, d};
    return (e << 13) - (e << 7) - (e << 6);
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign div_busy    = (div_cnt_q != '0);

  // One restoring division step.
  always_comb begin
    rr      = {div_r_q, div_x_q[DIVD_W-1]};
    ge      = (rr >= {1'b0, ent_q.dt});
    rsub    = rr - {1'b0, ent_q.dt};
    rate_ok = (ent_q.dt != '0) && (div_quo_q < {{(DIVD_W-RATE_W){1'b0}}, rate_limit_i});
  end

  // Average blend operands and sum.
  always_comb begin
    w         = avg_weight(idx_q);
    avg_rate  = (idx_q < 3'd3) ? cur_in_q : cur_out_q;
    blend_sum = {2'b0, p_new_q} + {2'b0, p_old_q} + 64'd32768;
  end

  // Report tap, clamped to the oldest entry.
  always_comb begin
    tap_ext = {5'b0, history_tap_i};
    if (tap_ext > 9'(HISTORY_DEPTH - 1)) begin
      tap_ext = 9'(HISTORY_DEPTH - 1);
    end
    tap = tap_ext[IDX_W-1:0];
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.kind == ST_FIRST || q_entry_i.kind == ST_BACK) begin
            state_d = B_EMIT;
          end else begin
            state_d = B_DIV_IN;
          end
        end
      end
      B_DIV_IN:  if (!div_busy) state_d = B_DIV_OUT;
      B_DIV_OUT: begin
        if (!div_busy) state_d = (ent_q.kind == ST_SEED) ? B_EMIT : B_AVG_MUL;
      end
      B_AVG_MUL: state_d = B_AVG_ADD;
      B_AVG_ADD: state_d = (idx_q == 3'(NUM_AVG - 1)) ? B_EMIT : B_AVG_MUL;
      B_EMIT:    if (out_free) state_d = B_IDLE;
      default:   state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else         state_q <= state_d;
  end

  // Divider and multiplier working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else begin
      if (state_q == B_IDLE && !q_empty_i) begin
        div_cnt_q <= 7'(DIVD_W);
      end else if (state_q == B_DIV_IN && !div_busy) begin
        div_cnt_q <= 7'(DIVD_W);
      end else if (div_busy) begin
        div_cnt_q <= div_cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !q_empty_i) begin
      ent_q     <= q_entry_i;
      div_x_q   <= times8000(q_entry_i.d_in);
      div_r_q   <= '0;
      div_quo_q <= '0;
    end else if (state_q == B_DIV_IN && !div_busy) begin
      div_x_q   <= times8000(ent_q.d_out);
      div_r_q   <= '0;
      div_quo_q <= '0;
    end else if (div_busy) begin
      div_x_q   <= {div_x_q[DIVD_W-2:0], 1'b0};
      div_r_q   <= ge ? rsub[TIME_W-1:0] : rr[TIME_W-1:0];
      div_quo_q <= {div_quo_q[DIVD_W-2:0], ge};
    end
    if (state_q == B_AVG_MUL) begin
      p_new_q <= w * {avg_rate, 8'b0};
      p_old_q <= (16'(17'd65536 - {1'b0, w})) * avg_q[idx_q];
    end
  end

  // Held rates, averages and history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_in_q  <= '0;
      cur_out_q <= '0;
      idx_q     <= '0;
      for (int i = 0; i < NUM_AVG; i++) avg_q[i] <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_in_q[i]  <= '0;
        hist_out_q[i] <= '0;
      end
    end else begin
      if (state_q == B_DIV_IN && !div_busy && rate_ok) begin
        cur_in_q <= div_quo_q[RATE_W-1:0];
      end
      if (state_q == B_DIV_OUT && !div_busy) begin
        logic [RATE_W-1:0] nout;
        nout = rate_ok ? div_quo_q[RATE_W-1:0] : cur_out_q;
        cur_out_q <= nout;
        idx_q     <= '0;
        if (ent_q.kind == ST_SEED) begin
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_in_q[i]  <= cur_in_q;
            hist_out_q[i] <= nout;
          end
          for (int i = 0; i < 3; i++) begin
            avg_q[i]     <= {cur_in_q, 8'b0};
            avg_q[i + 3] <= {nout, 8'b0};
          end
        end else begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_in_q[i]  <= hist_in_q[i - 1];
            hist_out_q[i] <= hist_out_q[i - 1];
          end
          hist_in_q[0]  <= cur_in_q;
          hist_out_q[0] <= nout;
        end
      end
      if (state_q == B_AVG_ADD) begin
        avg_q[idx_q] <= blend_sum[61:16];
        idx_q        <= idx_q + 3'd1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == B_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_EMIT && out_free) begin
      result_q.in_rate      <= cur_in_q;
      result_q.out_rate     <= cur_out_q;
      result_q.in_avg_fast  <= avg_q[0][AVG_W-1:8];
      result_q.in_avg_mid   <= avg_q[1][AVG_W-1:8];
      result_q.in_avg_slow  <= avg_q[2][AVG_W-1:8];
      result_q.out_avg_fast <= avg_q[3][AVG_W-1:8];
      result_q.out_avg_mid  <= avg_q[4][AVG_W-1:8];
      result_q.out_avg_slow <= avg_q[5][AVG_W-1:8];
      result_q.in_hist      <= hist_in_q[tap];
      result_q.out_hist     <= hist_out_q[tap];
      result_q.status       <= ent_q.kind;
    end
  end

endmodule

/* design/octet_counter_rate_meter.sv */
// ----------------------------------------------------------------------------
// Octet counter rate meter
// Interface bandwidth meter: rates from counter samples plus weighted averages.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  sample    in         in_valid/in_stall   time_ms, in_octets, out_octets
//  result    out        out_valid/out_stall rates, averages, history, status
//  config    in         psel/penable        rate_limit @0x0, history_tap @0x8
//
// A first or counter-back sample skips the divider; a seeding sample runs two
// serial 77-step divisions in one shared divider, and an averaging one adds
// six average updates, each a multiply step and an add step.
// Reset clears the control state, rates, averages and history at once; no clearing pass is needed.
// A two-entry queue lets samples arrive while the back end works, and the
// result register holds a transfer while out_stall is high.
`include "octet_counter_rate_meter_defines.svh"

module octet_counter_rate_meter import ocrm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TIME_W-1:0] time_ms_i,
  input  logic [OCT_W-1:0]  in_octets_i,
  input  logic [OCT_W-1:0]  out_octets_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RATE_W-1:0] in_rate_o,
  output logic [RATE_W-1:0] out_rate_o,
  output logic [RATE_W-1:0] in_avg_fast_o,
  output logic [RATE_W-1:0] in_avg_mid_o,
  output logic [RATE_W-1:0] in_avg_slow_o,
  output logic [RATE_W-1:0] out_avg_fast_o,
  output logic [RATE_W-1:0] out_avg_mid_o,
  output logic [RATE_W-1:0] out_avg_slow_o,
  output logic [RATE_W-1:0] in_hist_o,
  output logic [RATE_W-1:0] out_hist_o,
  output logic [1:0]        status_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [RATE_W-1:0] rate_limit_q;
  logic [TAP_W-1:0]  history_tap_q;
  logic              q_push, q_full, q_pop, q_empty;
  entry_t            q_in, q_out;
  result_t           res;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_limit_q  <= LIMIT_RESET;
      history_tap_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_LIMIT) rate_limit_q  <= pwdata[RATE_W-1:0];
      if (paddr == ADDR_TAP)   history_tap_q <= pwdata[TAP_W-1:0];
    end
  end

  always_comb begin
    case (paddr)
      ADDR_LIMIT: prdata = {{(64-RATE_W){1'b0}}, rate_limit_q};
      ADDR_TAP:   prdata = {{(64-TAP_W){1'b0}}, history_tap_q};
      default:    prdata = '0;
    endcase
  end

  ocrm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .time_ms_i, .in_octets_i,
    .out_octets_i, .q_full_i(q_full), .q_push_o(q_push), .q_entry_o(q_in)
  );

  ocrm_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .entry_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .entry_o(q_out)
  );

  ocrm_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_entry_i(q_out), .q_pop_o(q_pop),
    .rate_limit_i(rate_limit_q), .history_tap_i(history_tap_q),
    .out_valid_o, .out_stall_i, .result_o(res)
  );

  assign in_rate_o      = res.in_rate;
  assign out_rate_o     = res.out_rate;
  assign in_avg_fast_o  = res.in_avg_fast;
  assign in_avg_mid_o   = res.in_avg_mid;
  assign in_avg_slow_o  = res.in_avg_slow;
  assign out_avg_fast_o = res.out_avg_fast;
  assign out_avg_mid_o  = res.out_avg_mid;
  assign out_avg_slow_o = res.out_avg_slow;
  assign in_hist_o      = res.in_hist;
  assign out_hist_o     = res.out_hist;
  assign status_o       = res.status;

  // A seeded result reports history and averages equal to the rate.
  `OCRM_ASSERT_IMPL(a_seed_hist, out_valid_o && status_o == ST_SEED, in_hist_o == in_rate_o && out_hist_o == out_rate_o, "seeded history differs from rate")
  `OCRM_ASSERT_IMPL(a_seed_avg, out_valid_o && status_o == ST_SEED, in_avg_slow_o == in_rate_o && out_avg_fast_o == out_rate_o, "seeded average differs from rate")
  // The queue never takes a sample while it reports full.
  `OCRM_ASSERT(a_no_push_full, !(q_push && q_full), "push into a full queue")

endmodule
